@@ sv/sks_pkg.sv @@
// Shared constants, register indexes and controller command type for the Kalman smoother.
package sks_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SAMPLE_W      = 16;
	localparam int EST_W         = 32;
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_W        = GAIN_BITS + 1;
	localparam int VAR_W         = 40;
	localparam int NOISE_W       = 32;
	localparam int CFG_IDX_W     = 1;
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 56;
	localparam int DIV_STEPS     = GAIN_BITS + 1;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

	localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 32'd20;
	localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 32'd327680;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
	localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

	typedef struct packed {
		logic load_in;
		logic pred;
		logic den;
		logic div_step;
		logic gain;
		logic mul_lo;
		logic mul_hi;
		logic mul_var;
		logic acc_load;
		logic acc_add;
		logic est;
		logic var_upd;
		logic load_out;
	} sks_cmd_t;

endpackage

@@ sv/scalar_kalman_smoother.sv @@
// Top level of the scalar Kalman smoother: stream ports, config port, controller and datapath.
// Usage:
//  Input stream s_axis: one signed 16-bit sample per word, taken when tvalid and tready.
//  Output stream m_axis: one word per sample with the new estimate (signed, FRAC_BITS
//  fraction bits) and the gain used (unsigned Q1.16, 65536 is one).
//  Config port: cfg_we with cfg_index 0 writes process noise Q, index 1 measurement
//  noise R, both unsigned with FRAC_BITS fraction bits; write only while idle.
//  m_axis_tvalid rises once the sequencer has run all its steps for the word and loaded the output.
//  A new sample waits for the 17-step restoring divider for the gain and the two
//  two-pass products on the shared 17 x half-width multiplier.
//  s_axis_tready is high only while the sequencer is idle.
//  The output register lets a new sample be taken while the last result still waits;
//  if the receiver stalls, the next result is held inside until the output is free.
//  Reset: Q = 20, R = 327680, estimate and variance cleared, output empty.
module scalar_kalman_smoother #(
	parameter int FRAC_BITS = sks_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [sks_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] sample
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [sks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] estimate, [48:32] gain
	input  logic                               cfg_we,
	input  logic [sks_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sks_pkg::NOISE_W-1:0]        cfg_data
);
	import sks_pkg::*;

	sks_cmd_t                  cmd;
	logic signed [EST_W-1:0]   estimate;
	logic [GAIN_W-1:0]         gain;

	sks_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd)
	);

	sks_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (s_axis_tdata[SAMPLE_W-1:0]),
		.estimate  (estimate),
		.gain      (gain)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - EST_W - GAIN_W){1'b0}}, gain, estimate};

endmodule

@@ sv/sks_datapath.sv @@
// Datapath: config registers, filter state, serial divider, split multiplier, output word.
module sks_datapath #(
	parameter int FRAC_BITS = sks_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sks_pkg::sks_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [sks_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sks_pkg::NOISE_W-1:0]         cfg_data,
	input  logic signed [sks_pkg::SAMPLE_W-1:0] sample,
	output logic signed [sks_pkg::EST_W-1:0]    estimate,
	output logic [sks_pkg::GAIN_W-1:0]          gain
);
	import sks_pkg::*;

	localparam int MEAS_W  = SAMPLE_W + FRAC_BITS;
	localparam int INNOV_W = ((MEAS_W > EST_W) ? MEAS_W : EST_W) + 1;
	localparam int DEN_W   = VAR_W + 1;
	localparam int REM_W   = DEN_W + 1;
	localparam int OPW_RAW = (INNOV_W > VAR_W) ? INNOV_W : VAR_W;
	localparam int OPW     = OPW_RAW + (OPW_RAW % 2);
	localparam int CH      = OPW / 2;
	localparam int PP_W    = GAIN_W + CH;
	localparam int ACC_W   = GAIN_W + OPW;
	localparam int RND_W   = ACC_W - GAIN_BITS;
	localparam int SUM_W   = RND_W + 2;

	logic [NOISE_W-1:0]        q_noise_q;
	logic [NOISE_W-1:0]        r_noise_q;
	logic signed [EST_W-1:0]   prior_q;
	logic [VAR_W-1:0]          var_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [VAR_W-1:0]          p_q;
	logic [DEN_W-1:0]          den_q;
	logic [REM_W-1:0]          rem_q;
	logic [GAIN_W-1:0]         quot_q;
	logic [GAIN_W-1:0]         gain_q;
	logic signed [INNOV_W-1:0] innov_q;
	logic [INNOV_W-1:0]        mag_q;
	logic                      neg_q;
	logic [PP_W-1:0]           pp_s1;
	logic [ACC_W-1:0]          acc_q;
	logic signed [EST_W-1:0]   est_out_q;
	logic [GAIN_W-1:0]         gain_out_q;

	logic [DEN_W-1:0]          p_sum;
	logic [VAR_W-1:0]          p_next;
	logic signed [INNOV_W-1:0] meas;
	logic                      div_ge;
	logic [REM_W-1:0]          div_diff;
	logic [GAIN_W-1:0]         mul_a;
	logic [OPW-1:0]            mul_b;
	logic [CH-1:0]             mul_chunk;
	logic [ACC_W-1:0]          acc_rnd;
	logic [RND_W-1:0]          rnd;
	logic signed [SUM_W-1:0]   est_sum;
	logic                      est_fits;
	logic signed [EST_W-1:0]   est_sat;

	assign p_sum  = DEN_W'(var_q) + DEN_W'(q_noise_q);
	assign p_next = p_sum[DEN_W-1] ? VAR_MAX : p_sum[VAR_W-1:0];
	assign meas   = INNOV_W'(sample_q) <<< FRAC_BITS;

	assign div_ge   = rem_q >= REM_W'(den_q);
	assign div_diff = div_ge ? (rem_q - REM_W'(den_q)) : rem_q;

	assign mul_a     = cmd.mul_var ? (GAIN_ONE - gain_q) : gain_q;
	assign mul_b     = cmd.mul_var ? OPW'(p_q) : OPW'(mag_q);
	assign mul_chunk = cmd.mul_hi ? mul_b[OPW-1 -: CH] : mul_b[CH-1:0];

	assign acc_rnd  = acc_q + (ACC_W'(1) << (GAIN_BITS - 1));
	assign rnd      = acc_rnd[ACC_W-1:GAIN_BITS];
	assign est_sum  = SUM_W'(prior_q) + (neg_q ? -$signed(SUM_W'(rnd)) : $signed(SUM_W'(rnd)));
	assign est_fits = (est_sum[SUM_W-1:EST_W-1] == '0) || (est_sum[SUM_W-1:EST_W-1] == '1);
	assign est_sat  = est_fits ? est_sum[EST_W-1:0] :
		(est_sum[SUM_W-1] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= PROCESS_NOISE_RST;
			r_noise_q <= MEASURE_NOISE_RST;
			prior_q   <= '0;
			var_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PROCESS_NOISE: q_noise_q <= cfg_data;
					REG_MEASURE_NOISE: r_noise_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.est)
				prior_q <= est_sat;
			if (cmd.var_upd)
				var_q <= acc_q[GAIN_BITS +: VAR_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			sample_q <= sample;
		if (cmd.pred)
			p_q <= p_next;
		if (cmd.den) begin
			den_q   <= DEN_W'(p_q) + DEN_W'(r_noise_q);
			rem_q   <= REM_W'(p_q);
			innov_q <= meas - INNOV_W'(prior_q);
		end
		if (cmd.div_step) begin
			rem_q  <= div_diff << 1;
			quot_q <= {quot_q[GAIN_W-2:0], div_ge};
		end
		if (cmd.gain) begin
			gain_q <= (den_q == '0) ? '0 : quot_q;
			neg_q  <= innov_q[INNOV_W-1];
			mag_q  <= innov_q[INNOV_W-1] ? INNOV_W'(-innov_q) : INNOV_W'(innov_q);
		end
		if (cmd.mul_lo || cmd.mul_hi)
			pp_s1 <= PP_W'(mul_a) * PP_W'(mul_chunk);
		if (cmd.acc_load)
			acc_q <= ACC_W'(pp_s1);
		else if (cmd.acc_add)
			acc_q <= acc_q + (ACC_W'(pp_s1) << CH);
		if (cmd.load_out) begin
			est_out_q  <= prior_q;
			gain_out_q <= gain_q;
		end
	end

	assign estimate = est_out_q;
	assign gain     = gain_out_q;

endmodule

@@ sv/sks_ctrl.sv @@
// Controller: sequences predict, divide, multiply and update steps for one word.
module sks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	output logic              m_valid,
	input  logic              m_ready,
	output sks_pkg::sks_cmd_t cmd
);
	import sks_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PRED, S_DEN, S_DIV, S_GAIN, S_ML0, S_ML1, S_ML2,
		S_EST, S_MV0, S_MV1, S_MV2, S_VAR, S_DONE
	} state_t;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 m_valid_q;
	logic                 out_free;

	assign out_free = !m_valid_q || m_ready;
	assign s_ready  = (state_q == S_IDLE);
	assign m_valid  = m_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == S_IDLE) && s_valid;
		cmd.pred     = (state_q == S_PRED);
		cmd.den      = (state_q == S_DEN);
		cmd.div_step = (state_q == S_DIV);
		cmd.gain     = (state_q == S_GAIN);
		cmd.mul_lo   = (state_q == S_ML0) || (state_q == S_MV0);
		cmd.mul_hi   = (state_q == S_ML1) || (state_q == S_MV1);
		cmd.mul_var  = (state_q == S_MV0) || (state_q == S_MV1);
		cmd.acc_load = (state_q == S_ML1) || (state_q == S_MV1);
		cmd.acc_add  = (state_q == S_ML2) || (state_q == S_MV2);
		cmd.est      = (state_q == S_EST);
		cmd.var_upd  = (state_q == S_VAR);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				m_valid_q <= 1'b1;
			else if (m_ready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_valid) state_q <= S_PRED;
				S_PRED: state_q <= S_DEN;
				S_DEN: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == DIV_LAST)
						state_q <= S_GAIN;
					else
						div_cnt_q <= div_cnt_q + 1'b1;
				end
				S_GAIN: state_q <= S_ML0;
				S_ML0:  state_q <= S_ML1;
				S_ML1:  state_q <= S_ML2;
				S_ML2:  state_q <= S_EST;
				S_EST:  state_q <= S_MV0;
				S_MV0:  state_q <= S_MV1;
				S_MV1:  state_q <= S_MV2;
				S_MV2:  state_q <= S_VAR;
				S_VAR:  state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_div_runs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q != DIV_LAST) |=> (state_q == S_DIV))
		else $error("divider left early");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> (state_q == S_PRED))
		else $error("accepted word did not start");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_valid_q || m_ready))
		else $error("output word overwritten");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (m_valid_q && state_q == S_IDLE))
		else $error("loaded word not presented");
`endif

endmodule
